/* rtl/lzw_pkg.sv */
// Shared types, constants and helpers for the LZW encoder.
// No dependencies; imported by lzw_encoder.
package lzw_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int DICT_AW      = $clog2(DICT_ENTRIES);
  localparam int CODE_W       = 12;
  localparam int LIMIT_W      = 13;
  localparam int ROOT_W       = 5;
  localparam int ROOT_CODES   = 27;

  localparam logic [7:0] SYM_HASH = 8'h23;
  localparam logic [7:0] SYM_A    = 8'h41;
  localparam logic [7:0] SYM_Z    = 8'h5A;

  localparam logic [CODE_W-1:0] NO_CODE = '0;

  // Sibling-list node: character of this entry and the next child of the same parent
  typedef struct packed {
    logic [ROOT_W-1:0] ch;
    logic [CODE_W-1:0] sib;
  } node_t;

  typedef struct packed {
    logic              ok;
    logic [ROOT_W-1:0] code;
  } root_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_MISS,
    S_LINK,
    S_FLUSH,
    S_BAD
  } lzw_state_t;

  function automatic root_t root_of(input logic [7:0] sym);
    root_t r;
    logic [7:0] d;
    d      = sym - SYM_A;
    r.ok   = 1'b0;
    r.code = '0;
    if (sym == SYM_HASH) begin
      r.ok = 1'b1;
    end else if (sym >= SYM_A && sym <= SYM_Z) begin
      r.ok   = 1'b1;
      r.code = ROOT_W'(d + 8'd1);
    end
    return r;
  endfunction

endpackage

/* rtl/lzw_encoder.sv */
// LZW encoder top level: prefix tracking, trie walk over block memories, result register.
// Depends on lzw_pkg.
//
// One character word is taken when the block is idle. The dictionary is a trie held in two
// memories with separate read and write ports: a head memory giving each code's first child
// and a node memory giving each entry's character and next sibling; the 27 root codes keep
// their first-child links in flip-flops. A word is accepted, the head of its prefix is read,
// then the sibling list is walked entry by entry (at most 27 siblings); on a miss the prefix
// code is emitted and, while the dictionary has room, a new entry is linked in; the end of text
// flushes the pending code. The walk through the sibling list is the limiting loop. No clearing
// pass is needed after reset. Results leave through a single output register, so a new word can
// be accepted while the previous result still waits downstream.
module lzw_encoder
  import lzw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_symbol,
  input  logic                in_end_of_input,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   out_code,
  output logic                out_bad_symbol,
  output logic                out_final_code,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data
);

  localparam logic [LIMIT_W-1:0] DICT_CAP   = LIMIT_W'(DICT_ENTRIES);
  localparam logic [LIMIT_W-1:0] ROOT_FIRST = LIMIT_W'(ROOT_CODES);
  localparam logic [CODE_W-1:0]  ROOT_TOP   = CODE_W'(ROOT_CODES);

  // memories
  logic [CODE_W-1:0] head_mem [DICT_ENTRIES];
  node_t             node_mem [DICT_ENTRIES];

  logic              head_we;
  logic [DICT_AW-1:0] head_waddr, head_raddr;
  logic [CODE_W-1:0] head_wdata, head_rd_r;
  logic              node_we;
  logic [DICT_AW-1:0] node_waddr, node_raddr;
  node_t             node_wdata, node_rd_r;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_r <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_r <= node_mem[node_raddr];
  end

  // control and datapath registers
  lzw_state_t         state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] nfc_r, nfc_nxt;
  logic [CODE_W-1:0]  prefix_r, prefix_nxt;
  logic               pv_r, pv_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic               eoi_r, eoi_nxt;
  logic [CODE_W-1:0]  cur_r, cur_nxt;
  logic [CODE_W-1:0]  head_r, head_nxt;

  logic [CODE_W-1:0]  rhead_r   [ROOT_CODES];
  logic [ROOT_CODES-1:0] rvld_r;
  logic               rhead_we;

  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic               out_bad_r, out_bad_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic               out_load;

  root_t              in_root;
  logic               accept;
  logic               out_free;
  logic [LIMIT_W-1:0] cap;
  logic               room;
  logic               prefix_is_root;
  logic [CODE_W-1:0]  root_head;
  logic [CODE_W-1:0]  head_val;

  assign in_root        = root_of(in_symbol);
  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_free       = !out_valid_r || !out_stall;
  assign cap            = (limit_r > DICT_CAP) ? DICT_CAP : limit_r;
  assign room           = (nfc_r < cap);
  assign prefix_is_root = (prefix_r < ROOT_TOP);
  assign root_head      = rvld_r[prefix_r[ROOT_W-1:0]] ? rhead_r[prefix_r[ROOT_W-1:0]] : NO_CODE;
  assign head_val       = prefix_is_root ? root_head : head_rd_r;

  always_comb begin
    state_nxt    = state_r;
    nfc_nxt      = nfc_r;
    prefix_nxt   = prefix_r;
    pv_nxt       = pv_r;
    root_nxt     = root_r;
    eoi_nxt      = eoi_r;
    cur_nxt      = cur_r;
    head_nxt     = head_r;
    out_load     = 1'b0;
    out_code_nxt = out_code_r;
    out_bad_nxt  = out_bad_r;
    out_fin_nxt  = out_fin_r;
    head_we      = 1'b0;
    head_waddr   = nfc_r[DICT_AW-1:0];
    head_wdata   = NO_CODE;
    head_raddr   = prefix_r[DICT_AW-1:0];
    node_we      = 1'b0;
    node_waddr   = nfc_r[DICT_AW-1:0];
    node_wdata   = '{ch: root_r, sib: head_r};
    node_raddr   = cur_r[DICT_AW-1:0];
    rhead_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          root_nxt = in_root.code;
          eoi_nxt  = in_end_of_input;
          if (!in_root.ok) begin
            state_nxt = S_BAD;
          end else if (!pv_r) begin
            prefix_nxt = CODE_W'(in_root.code);
            pv_nxt     = 1'b1;
            state_nxt  = in_end_of_input ? S_FLUSH : S_IDLE;
          end else begin
            // head read of the current prefix issued here
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        head_nxt = head_val;
        if (head_val == NO_CODE) begin
          state_nxt = S_MISS;
        end else begin
          cur_nxt    = head_val;
          node_raddr = head_val[DICT_AW-1:0];
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (node_rd_r.ch == root_r) begin
          prefix_nxt = cur_r;
          state_nxt  = eoi_r ? S_FLUSH : S_IDLE;
        end else if (node_rd_r.sib == NO_CODE) begin
          state_nxt = S_MISS;
        end else begin
          cur_nxt    = node_rd_r.sib;
          node_raddr = node_rd_r.sib[DICT_AW-1:0];
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_code_nxt = prefix_r;
          out_bad_nxt  = 1'b0;
          out_fin_nxt  = 1'b0;
          if (room) begin
            // new node goes at the head of the parent's child list
            node_we   = 1'b1;
            head_we   = 1'b1;
            state_nxt = S_LINK;
          end else begin
            prefix_nxt = CODE_W'(root_r);
            state_nxt  = eoi_r ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_LINK: begin
        if (prefix_is_root) begin
          rhead_we = 1'b1;
        end else begin
          head_we    = 1'b1;
          head_waddr = prefix_r[DICT_AW-1:0];
          head_wdata = nfc_r[CODE_W-1:0];
        end
        nfc_nxt    = nfc_r + LIMIT_W'(1);
        prefix_nxt = CODE_W'(root_r);
        state_nxt  = eoi_r ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_code_nxt = prefix_r;
          out_bad_nxt  = 1'b0;
          out_fin_nxt  = 1'b1;
          pv_nxt       = 1'b0;
          prefix_nxt   = NO_CODE;
          state_nxt    = S_IDLE;
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_code_nxt = NO_CODE;
          out_bad_nxt  = 1'b1;
          out_fin_nxt  = eoi_r && !pv_r;
          state_nxt    = (eoi_r && pv_r) ? S_FLUSH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= DICT_CAP;
      nfc_r       <= ROOT_FIRST;
      prefix_r    <= NO_CODE;
      pv_r        <= 1'b0;
      rvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nfc_r    <= nfc_nxt;
      prefix_r <= prefix_nxt;
      pv_r     <= pv_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (rhead_we) begin
        rvld_r[prefix_r[ROOT_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    root_r     <= root_nxt;
    eoi_r      <= eoi_nxt;
    cur_r      <= cur_nxt;
    head_r     <= head_nxt;
    out_code_r <= out_code_nxt;
    out_bad_r  <= out_bad_nxt;
    out_fin_r  <= out_fin_nxt;
    if (rhead_we) begin
      rhead_r[prefix_r[ROOT_W-1:0]] <= nfc_r[CODE_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_bad_symbol = out_bad_r;
  assign out_final_code = out_fin_r;

  // free-code counter never leaves the dictionary range
  a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nfc_r >= ROOT_FIRST) && (nfc_r <= DICT_CAP))
    else $error("next free code out of range");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // the walk only visits entries already created
  a_walk_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((cur_r >= ROOT_TOP) && ({1'b0, cur_r} < nfc_r)))
    else $error("trie walk reached an unwritten entry");

  // no pending prefix means the prefix register is cleared
  a_prefix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !pv_r |-> (prefix_r == NO_CODE))
    else $error("stale prefix without pending string");

endmodule
